/* hw/rtl/rtfi_pkg.sv */
// Shared types and constants for the route table find-or-insert block.
// Depends on nothing; used by rtfi_table_mem and route_table_find_or_insert.
package rtfi_pkg;

  localparam int TABLE_SLOTS_DEF = 16;

  localparam int ENTRY_W = 31;
  localparam int KEY_W   = 23;
  localparam int AMT_W   = 8;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

/* hw/rtl/route_table_find_or_insert.sv */
// Top level of the route table: add/update, remove and find over a slot table.
// Depends on rtfi_pkg and rtfi_table_mem.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  input    | start / busy        | in_mode, in_source_type, in_source_index,
//           |                     | in_dest_controller, in_dest_channel,
//           |                     | in_route_amount, in_slot_to_clear
//  result   | out_valid (strobe)  | out_success, out_slot_index, out_used_count
//
// Add and find walk the table once through the memory read port, one slot per
// cycle. Remove reads the cleared slot once. Reset is synchronous: per-slot
// valid flags empty the table. The result strobe lasts one cycle; busy drops
// as it is produced, so the next transaction may be accepted while the result
// is on the ports.
module route_table_find_or_insert #(
  parameter int TABLE_SLOTS = rtfi_pkg::TABLE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_mode,
  input  logic [3:0]                  in_source_type,
  input  logic [7:0]                  in_source_index,
  input  logic [6:0]                  in_dest_controller,
  input  logic [3:0]                  in_dest_channel,
  input  logic signed [7:0]           in_route_amount,
  input  logic [5:0]                  in_slot_to_clear,
  output logic                        out_valid,
  output logic                        out_success,
  output logic [rtfi_pkg::SLOT_W-1:0] out_slot_index,
  output logic [rtfi_pkg::COUNT_W-1:0] out_used_count
);
  import rtfi_pkg::*;

  localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RM_WAIT,
    ST_FINISH
  } state_t;

  state_t             state_r;
  logic [1:0]         mode_r;
  logic [KEY_W-1:0]   key_r;
  logic [AMT_W-1:0]   amt_r;
  logic [AW-1:0]      rm_slot_r;
  logic [CW-1:0]      rd_idx_r;
  logic [AW-1:0]      chk_idx_r;
  logic               chk_vld_r;
  logic               match_found_r;
  logic               match_used_r;
  logic [AW-1:0]      match_idx_r;
  logic               empty_found_r;
  logic [AW-1:0]      empty_idx_r;
  logic [COUNT_W-1:0] count_r;
  logic               out_valid_r;
  logic               out_success_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               issuing;
  logic               rm_in_range;
  logic               key_hit;
  logic               entry_empty;
  logic               add_ok;
  logic [AW-1:0]      add_idx;
  entry_t             new_entry;
  logic               new_used;
  logic [COUNT_W-1:0] add_count_nxt;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic [AW-1:0]      mem_raddr;
  entry_t             mem_rdata;

  rtfi_table_mem #(
    .DEPTH (TABLE_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign issuing     = (state_r == ST_SCAN) && (rd_idx_r < CW'(TABLE_SLOTS));
  assign rm_in_range = ({1'b0, in_slot_to_clear} < 7'(TABLE_SLOTS));
  assign key_hit     = (mem_rdata[ENTRY_W-1:AMT_W] == key_r);
  assign entry_empty = (mem_rdata == '0);
  assign new_entry   = {key_r, amt_r};
  assign new_used    = (new_entry != '0);
  assign add_ok      = match_found_r || empty_found_r;
  assign add_idx     = match_found_r ? match_idx_r : empty_idx_r;

  // A new key always lands in an empty slot and is never all zero, because an
  // all-zero key would have matched that empty slot.
  always_comb begin
    if (match_found_r) begin
      add_count_nxt = count_r + COUNT_W'(new_used) - COUNT_W'(match_used_r);
    end else if (empty_found_r) begin
      add_count_nxt = count_r + COUNT_W'(1);
    end else begin
      add_count_nxt = count_r;
    end
  end

  always_comb begin
    mem_raddr = rd_idx_r[AW-1:0];
    if (state_r == ST_IDLE) begin
      mem_raddr = in_slot_to_clear[AW-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = add_idx;
    mem_wdata = new_entry;
    unique case (state_r)
      ST_FINISH: begin
        mem_we = (mode_r == MODE_ADD) && add_ok;
      end
      ST_RM_WAIT: begin
        mem_we    = 1'b1;
        mem_waddr = rm_slot_r;
        mem_wdata = '0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      out_success_r <= 1'b0;
      out_slot_r    <= '0;
      out_count_r   <= '0;
      chk_vld_r     <= 1'b0;
      match_found_r <= 1'b0;
      empty_found_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            mode_r        <= in_mode;
            key_r         <= {in_source_type, in_source_index, in_dest_controller,
                              in_dest_channel};
            amt_r         <= in_route_amount;
            rm_slot_r     <= in_slot_to_clear[AW-1:0];
            rd_idx_r      <= '0;
            chk_vld_r     <= 1'b0;
            match_found_r <= 1'b0;
            empty_found_r <= 1'b0;
            if (in_mode == MODE_ADD || in_mode == MODE_FIND) begin
              state_r <= ST_SCAN;
            end else if (in_mode == MODE_REMOVE && rm_in_range) begin
              state_r <= ST_RM_WAIT;
            end else begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          // Reads are issued one slot ahead of the compare on the returned data.
          if (issuing) begin
            rd_idx_r <= rd_idx_r + CW'(1);
          end
          chk_vld_r <= issuing;
          chk_idx_r <= rd_idx_r[AW-1:0];
          if (chk_vld_r) begin
            if (!match_found_r && key_hit) begin
              match_found_r <= 1'b1;
              match_idx_r   <= chk_idx_r;
              match_used_r  <= !entry_empty;
            end
            if (!empty_found_r && entry_empty) begin
              empty_found_r <= 1'b1;
              empty_idx_r   <= chk_idx_r;
            end
            if (chk_idx_r == AW'(TABLE_SLOTS - 1)) begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_RM_WAIT: begin
          if (!entry_empty) begin
            count_r     <= count_r - COUNT_W'(1);
            out_count_r <= count_r - COUNT_W'(1);
          end else begin
            out_count_r <= count_r;
          end
          out_valid_r   <= 1'b1;
          out_success_r <= 1'b0;
          out_slot_r    <= '0;
          state_r       <= ST_IDLE;
        end
        ST_FINISH: begin
          out_valid_r <= 1'b1;
          if (mode_r == MODE_ADD) begin
            count_r       <= add_count_nxt;
            out_count_r   <= add_count_nxt;
            out_success_r <= add_ok;
            out_slot_r    <= add_ok ? SLOT_W'(add_idx) : '0;
          end else if (mode_r == MODE_FIND) begin
            out_count_r   <= count_r;
            out_success_r <= match_found_r;
            out_slot_r    <= match_found_r ? SLOT_W'(match_idx_r) : '0;
          end else begin
            out_count_r   <= count_r;
            out_success_r <= 1'b0;
            out_slot_r    <= '0;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_success    = out_success_r;
  assign out_slot_index = out_slot_r;
  assign out_used_count = out_count_r;

endmodule

/* hw/rtl/rtfi_table_mem.sv */
// Synchronous route table memory with one write and one registered read port.
// Per-entry valid flags make never-written entries read as empty after reset.
// Depends on rtfi_pkg.
module rtfi_table_mem #(
  parameter int DEPTH = rtfi_pkg::TABLE_SLOTS_DEF,
  parameter int AW    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  rtfi_pkg::entry_t     wdata,
  input  logic [AW-1:0]        raddr,
  output rtfi_pkg::entry_t     rdata
);
  import rtfi_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  entry_t           q_r;
  logic             q_valid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      q_valid_r <= valid_r[raddr];
    end
  end

  assign rdata = q_valid_r ? q_r : '0;

endmodule
